// ----- hdl/tst_pkg.sv -----
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types, constants and codes of the timer slot table.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int TIMER_SLOTS_DEF = 64;
  localparam int MAX_RESULTS     = 64;

  localparam int TIME_W  = 48;
  localparam int SPAN_W  = 32;
  localparam int ID_W    = 31;
  localparam int STAT_W  = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};
  localparam logic [ID_W-1:0]   ID_FIRST = ID_W'(1);

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FIRED    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NONE     = 3'd4;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
    logic [SPAN_W-1:0] period;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic              hit;
    logic              one_shot;
    logic [ID_W-1:0]   remain;
    logic [TIME_W-1:0] new_exp;
  } eval_t;

endpackage

// ----- hdl/timer_slot_table.sv -----
// ----------------------------------------------------------------------------
// timer_slot_table
// Table of timer slots with add, delete, query and tick commands.
//
// One transaction on the in_ channel carries a command; the block answers
// with one out_ transaction, or on a tick one per fired slot, out_last
// marking the final one. Valid/stall on both sides: in_stall stays high
// while a command is being worked, so commands are taken one at a time.
// Slot id, expiry and period live in a RAM with a single read port, read
// one slot per cycle unless the scan is held; the active flags are
// flip-flops cleared at reset, next id resets to 1. Add and delete stop
// at the first hit. Query walks all TIMER_SLOTS slots; a tick does too,
// but fires at most 64 slots and stops there; the rest fire on a later
// tick. When out_stall holds the output register, the scan pauses before
// it would need a second result slot, so results are never lost. In the
// idle state a new command can be accepted while the last result still
// waits in the output register.
// ----------------------------------------------------------------------------
module timer_slot_table import tst_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [TIME_W-1:0]        in_now_time,
  input  logic [SPAN_W-1:0]        in_delay,
  input  logic [SPAN_W-1:0]        in_interval,
  input  logic [ID_W-1:0]          in_target_id,
  input  logic signed [SPAN_W-1:0] in_wait_limit,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic [ID_W-1:0]          out_result_id,
  output logic signed [SPAN_W-1:0] out_wait_time,
  output logic                     out_last
);

  localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int FCNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TIMER_SLOTS - 1);
  localparam logic [FCNT_W-1:0] LAST_FIRE = FCNT_W'(MAX_RESULTS - 1);

  state_t state_r, state_nxt;

  kind_t              kind_r;
  logic [TIME_W-1:0]  now_r;
  logic [SPAN_W-1:0]  delay_r;
  logic [SPAN_W-1:0]  interval_r;
  logic [ID_W-1:0]    target_r;

  logic [TIMER_SLOTS-1:0] active_r, active_nxt;
  logic [ID_W-1:0]        next_id_r, next_id_nxt;

  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              e_vld_r, e_vld_nxt;
  logic [IDX_W-1:0]  e_idx_r, e_idx_nxt;
  logic [FCNT_W-1:0] fire_cnt_r, fire_cnt_nxt;

  logic              q_unl_r, q_unl_nxt;
  logic [ID_W-1:0]   q_wait_r, q_wait_nxt;

  logic              pend_vld_r, pend_vld_nxt;
  logic [STAT_W-1:0] pend_stat_r, pend_stat_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [SPAN_W-1:0] pend_wait_r, pend_wait_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [STAT_W-1:0] out_stat_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SPAN_W-1:0] out_wait_r;
  logic              out_last_r;

  logic              accept, scan_en, out_free, out_load, out_load_last;
  logic              hold, eval_go, at_end, finish, advance, issue;
  logic              wr_en;
  slot_t             wr_slot, entry;
  logic [SLOT_W-1:0] rd_data;
  eval_t             ev;
  logic              q_unl_new;
  logic [ID_W-1:0]   q_wait_new;
  logic [SPAN_W-1:0] q_result;

  tst_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(e_idx_r),
    .wr_data(wr_slot),
    .rd_en  (issue),
    .rd_addr(rd_idx_r[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign entry = slot_t'(rd_data);

  tst_slot_eval u_eval (
    .kind     (kind_r),
    .now_time (now_r),
    .delay    (delay_r),
    .target_id(target_r),
    .entry    (entry),
    .active   (active_r[e_idx_r]),
    .ev       (ev)
  );

  // state outputs
  always_comb begin
    case (state_r)
      S_IDLE:  begin in_stall = 1'b0; scan_en = 1'b0; end
      S_SCAN:  begin in_stall = 1'b1; scan_en = 1'b1; end
      S_DONE:  begin in_stall = 1'b1; scan_en = 1'b0; end
      default: begin in_stall = 1'b1; scan_en = 1'b0; end
    endcase
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  // scan control
  always_comb begin
    hold    = e_vld_r && (kind_r == KIND_TICK) && ev.hit && pend_vld_r && !out_free;
    eval_go = scan_en && e_vld_r && !hold;
    at_end  = (e_idx_r == LAST_IDX);
    case (kind_r)
      KIND_ADD, KIND_DEL: finish = eval_go && (ev.hit || at_end);
      KIND_QUERY:         finish = eval_go && at_end;
      KIND_TICK:          finish = eval_go && (at_end || (ev.hit && fire_cnt_r == LAST_FIRE));
      default:            finish = 1'b0;
    endcase
    advance = !e_vld_r || eval_go;
    issue   = scan_en && !finish && advance && (rd_idx_r < CNT_W'(TIMER_SLOTS));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (finish) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // query minimum including the slot under evaluation
  always_comb begin
    q_unl_new  = q_unl_r;
    q_wait_new = q_wait_r;
    if (kind_r == KIND_QUERY && eval_go && ev.hit && (q_unl_r || ev.remain < q_wait_r)) begin
      q_unl_new  = 1'b0;
      q_wait_new = ev.remain;
    end
    q_result = q_unl_new ? '1 : {1'b0, q_wait_new};
  end

  // slot updates and result staging
  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    e_vld_nxt     = e_vld_r;
    e_idx_nxt     = e_idx_r;
    fire_cnt_nxt  = fire_cnt_r;
    active_nxt    = active_r;
    next_id_nxt   = next_id_r;
    q_unl_nxt     = q_unl_new;
    q_wait_nxt    = q_wait_new;
    pend_vld_nxt  = pend_vld_r;
    pend_stat_nxt = pend_stat_r;
    pend_id_nxt   = pend_id_r;
    pend_wait_nxt = pend_wait_r;
    wr_en         = 1'b0;
    wr_slot       = {entry.id, ev.new_exp, entry.period};
    out_load      = 1'b0;
    out_load_last = 1'b0;

    if (issue) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
      e_idx_nxt  = rd_idx_r[IDX_W-1:0];
    end
    if (advance) begin
      e_vld_nxt = issue;
    end

    if (eval_go && ev.hit) begin
      case (kind_r)
        KIND_ADD: begin
          wr_en             = 1'b1;
          wr_slot           = {next_id_r, ev.new_exp, interval_r};
          active_nxt[e_idx_r] = 1'b1;
          next_id_nxt       = (next_id_r == ID_MAX) ? ID_FIRST : next_id_r + ID_W'(1);
        end
        KIND_DEL: active_nxt[e_idx_r] = 1'b0;
        KIND_TICK: begin
          if (ev.one_shot) begin
            active_nxt[e_idx_r] = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
          fire_cnt_nxt = fire_cnt_r + FCNT_W'(1);
          if (pend_vld_r) begin
            out_load = 1'b1;
          end
          pend_vld_nxt  = 1'b1;
          pend_stat_nxt = STAT_FIRED;
          pend_id_nxt   = entry.id;
          pend_wait_nxt = '0;
        end
        default: ;
      endcase
    end

    if (finish) begin
      e_vld_nxt = 1'b0;
      case (kind_r)
        KIND_ADD: begin
          pend_vld_nxt  = 1'b1;
          pend_stat_nxt = ev.hit ? STAT_OK : STAT_FULL;
          pend_id_nxt   = ev.hit ? next_id_r : '0;
          pend_wait_nxt = '0;
        end
        KIND_DEL: begin
          pend_vld_nxt  = 1'b1;
          pend_stat_nxt = ev.hit ? STAT_OK : STAT_NOTFOUND;
          pend_id_nxt   = '0;
          pend_wait_nxt = '0;
        end
        KIND_QUERY: begin
          pend_vld_nxt  = 1'b1;
          pend_stat_nxt = STAT_OK;
          pend_id_nxt   = '0;
          pend_wait_nxt = q_result;
        end
        KIND_TICK: begin
          if (!ev.hit && !pend_vld_r) begin
            pend_vld_nxt  = 1'b1;
            pend_stat_nxt = STAT_NONE;
            pend_id_nxt   = '0;
            pend_wait_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    if (state_r == S_DONE && out_free) begin
      out_load      = 1'b1;
      out_load_last = 1'b1;
      pend_vld_nxt  = 1'b0;
    end

    if (accept) begin
      rd_idx_nxt   = '0;
      e_vld_nxt    = 1'b0;
      fire_cnt_nxt = '0;
      pend_vld_nxt = 1'b0;
      q_unl_nxt    = in_wait_limit[SPAN_W-1];
      q_wait_nxt   = in_wait_limit[ID_W-1:0];
    end

    out_vld_nxt = out_load ? 1'b1 : (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      active_r   <= '0;
      next_id_r  <= ID_FIRST;
      rd_idx_r   <= '0;
      e_vld_r    <= 1'b0;
      fire_cnt_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      next_id_r  <= next_id_nxt;
      rd_idx_r   <= rd_idx_nxt;
      e_vld_r    <= e_vld_nxt;
      fire_cnt_r <= fire_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_idx_r     <= e_idx_nxt;
    q_unl_r     <= q_unl_nxt;
    q_wait_r    <= q_wait_nxt;
    pend_stat_r <= pend_stat_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_wait_r <= pend_wait_nxt;
    if (accept) begin
      kind_r     <= kind_t'(in_kind);
      now_r      <= in_now_time;
      delay_r    <= in_delay;
      interval_r <= in_interval;
      target_r   <= in_target_id;
    end
    if (out_load) begin
      out_stat_r <= pend_stat_r;
      out_id_r   <= pend_id_r;
      out_wait_r <= pend_wait_r;
      out_last_r <= out_load_last;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_stat_r;
  assign out_result_id = out_id_r;
  assign out_wait_time = out_wait_r;
  assign out_last      = out_last_r;

  a_done_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid && out_last && state_r == S_IDLE))
    else $error("final result not presented on leaving done state");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pend_vld_r && !e_vld_r))
    else $error("scan state left behind in idle");

  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> pend_vld_r)
    else $error("done state without a staged result");

  a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fire_cnt_r <= FCNT_W'(MAX_RESULTS))
    else $error("tick fired more slots than allowed");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0)
    else $error("next id reached zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_status) && $stable(out_result_id))
    else $error("stalled result overwritten");

endmodule

// ----- hdl/tst_ram.sv -----
// ----------------------------------------------------------------------------
// tst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/tst_slot_eval.sv -----
// ----------------------------------------------------------------------------
// tst_slot_eval
// Evaluates one slot entry against the command in progress: hit test,
// remaining time and saturated new expiry.
// ----------------------------------------------------------------------------
module tst_slot_eval import tst_pkg::*; (
  input  kind_t             kind,
  input  logic [TIME_W-1:0] now_time,
  input  logic [SPAN_W-1:0] delay,
  input  logic [ID_W-1:0]   target_id,
  input  slot_t             entry,
  input  logic              active,
  output eval_t             ev
);

  logic [SPAN_W-1:0] addend;
  logic [TIME_W:0]   sum;
  logic [TIME_W:0]   dif;
  logic              expired;

  always_comb begin
    addend  = (kind == KIND_ADD) ? delay : entry.period;
    sum     = {1'b0, now_time} + {{(TIME_W-SPAN_W+1){1'b0}}, addend};
    dif     = {1'b0, entry.expiry} - {1'b0, now_time};
    expired = dif[TIME_W] || (dif == '0);

    ev.new_exp  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    ev.one_shot = (entry.period == '0);
    if (dif[TIME_W]) begin
      ev.remain = '0;
    end else if (|dif[TIME_W-1:ID_W]) begin
      ev.remain = ID_MAX;
    end else begin
      ev.remain = dif[ID_W-1:0];
    end

    case (kind)
      KIND_ADD:   ev.hit = !active;
      KIND_DEL:   ev.hit = active && (entry.id == target_id);
      KIND_QUERY: ev.hit = active;
      KIND_TICK:  ev.hit = active && expired;
      default:    ev.hit = 1'b0;
    endcase
  end

endmodule
